FILE: src/tccs_pkg.sv
// Shared types and constants for the text console cursor/scroll unit.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package tccs_pkg;

    // Request modes
    localparam logic [1:0] MODE_PUT  = 2'd0;
    localparam logic [1:0] MODE_SET  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    // Control bytes
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_SPACE = 8'd32;

    localparam logic [7:0]  RESET_COLOR = 8'h07;
    localparam logic [15:0] BLANK_CELL  = {RESET_COLOR, CH_SPACE};

    // Register indexes
    localparam logic REG_TEXT_COLOR = 1'b0;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] char_code;
        logic [6:0] column;
        logic [4:0] row;
    } req_t;

    typedef struct packed {
        logic [6:0] cursor_column;
        logic [4:0] cursor_row;
        logic [7:0] cell_char;
        logic [7:0] cell_color;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic clear;      // write one blank cell of the reset sweep
        logic capture;    // latch the incoming request
        logic exec;       // carry out the latched request
        logic scroll;     // one step of the row copy
        logic sweep_clr;  // restart the sweep counter
        logic load;       // load the result register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic scroll_last;
        logic need_scroll;
    } sts_t;

endpackage

`default_nettype wire

FILE: src/tccs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/tccs_ctrl.sv
// Sequencer for the text console: reset sweep, request execution, row scroll
// and result hand-off. Depends on tccs_pkg.
`default_nettype none

module tccs_ctrl
    import tccs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output cmd_t      cmd,
    input  wire sts_t sts
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_SCROLL = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec      = 1'b1;
                cmd.sweep_clr = 1'b1;
                state_next    = sts.need_scroll ? S_SCROLL : S_DONE;
            end
            S_SCROLL:
            begin
                cmd.scroll = 1'b1;
                if (sts.scroll_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hand off the result and take the next request in the same cycle
                if (out_free)
                begin
                    cmd.load  = 1'b1;
                    req_ready = 1'b1;
                    if (req_valid)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = S_EXEC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: src/tccs_datapath.sv
// Datapath: cursor registers, cell address generation, sweep counter, screen
// RAM and result register. Depends on tccs_pkg and tccs_ram.
`default_nettype none

module tccs_datapath
    import tccs_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire req_t       req,
    input  wire logic [7:0] text_color,
    input  wire cmd_t       cmd,
    output sts_t            sts,
    output rsp_t            rsp
);

    localparam int         CELLS      = COLUMNS * ROWS;
    localparam int         AW         = $clog2(CELLS);
    localparam int         SCROLL_LEN = CELLS - COLUMNS;
    localparam logic [6:0] COL_MAX    = 7'(COLUMNS - 1);
    localparam logic [4:0] ROW_MAX    = 5'(ROWS - 1);
    localparam logic [6:0] TAB_WRAP   = 7'd4;

    req_t          req_reg;
    rsp_t          rsp_reg;
    rsp_t          rsp_next;
    logic [6:0]    cur_col_reg;
    logic [6:0]    cur_col_next;
    logic [4:0]    cur_row_reg;
    logic [4:0]    cur_row_next;
    logic [AW-1:0] cnt_reg;
    logic [AW-1:0] cnt_next;

    logic [6:0]    req_col;
    logic [4:0]    req_row;
    logic [AW-1:0] cur_addr;
    logic [AW-1:0] req_addr;
    logic [7:0]    col_inc;
    logic [7:0]    tab_inc;
    logic [5:0]    row_inc;
    logic          advance;
    logic          put_we;
    logic          rd_req;
    logic          need_scroll;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    // saturate requested position
    assign req_col  = (req_reg.column > COL_MAX) ? COL_MAX : req_reg.column;
    assign req_row  = (req_reg.row > ROW_MAX) ? ROW_MAX : req_reg.row;
    assign cur_addr = AW'(int'(cur_row_reg) * COLUMNS + int'(cur_col_reg));
    assign req_addr = AW'(int'(req_row) * COLUMNS + int'(req_col));
    assign col_inc  = {1'b0, cur_col_reg} + 8'd1;
    assign tab_inc  = {1'b0, cur_col_reg} + 8'd5;
    assign row_inc  = {1'b0, cur_row_reg} + 6'd1;

    always_comb
    begin
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        advance      = 1'b0;
        put_we       = 1'b0;
        rd_req       = 1'b0;
        need_scroll  = 1'b0;
        if (cmd.exec)
        begin
            unique case (req_reg.mode)
                MODE_PUT:
                begin
                    unique case (req_reg.char_code)
                        CH_CR:
                        begin
                            cur_col_next = '0;
                        end
                        CH_LF:
                        begin
                            cur_col_next = '0;
                            advance      = 1'b1;
                        end
                        CH_TAB:
                        begin
                            if (tab_inc >= 8'(COLUMNS))
                            begin
                                cur_col_next = TAB_WRAP;
                                advance      = 1'b1;
                            end
                            else
                            begin
                                cur_col_next = tab_inc[6:0];
                            end
                        end
                        default:
                        begin
                            put_we = 1'b1;
                            if (col_inc >= 8'(COLUMNS))
                            begin
                                cur_col_next = '0;
                                advance      = 1'b1;
                            end
                            else
                            begin
                                cur_col_next = col_inc[6:0];
                            end
                        end
                    endcase
                end
                MODE_SET:
                begin
                    cur_col_next = req_col;
                    cur_row_next = req_row;
                end
                MODE_READ:
                begin
                    rd_req = 1'b1;
                end
                default:
                begin
                end
            endcase
            if (advance)
            begin
                if (row_inc >= 6'(ROWS))
                begin
                    cur_row_next = ROW_MAX;
                    need_scroll  = 1'b1;
                end
                else
                begin
                    cur_row_next = row_inc[4:0];
                end
            end
        end
    end

    // Sweep: reset clear writes cnt; scroll reads cnt+COLUMNS, writes cnt-1
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cur_addr;
        ram_wdata = {text_color, req_reg.char_code};
        ram_re    = 1'b0;
        ram_raddr = req_addr;
        if (cmd.clear)
        begin
            ram_we    = 1'b1;
            ram_waddr = cnt_reg;
            ram_wdata = BLANK_CELL;
        end
        else if (cmd.scroll)
        begin
            ram_we    = (cnt_reg != '0);
            ram_waddr = cnt_reg - AW'(1);
            ram_wdata = ram_rdata;
            ram_re    = (cnt_reg < AW'(SCROLL_LEN));
            ram_raddr = cnt_reg + AW'(COLUMNS);
        end
        else
        begin
            ram_we = put_we;
            ram_re = rd_req;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.sweep_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.clear || cmd.scroll)
        begin
            cnt_next = cnt_reg + AW'(1);
        end
    end

    always_comb
    begin
        rsp_next               = rsp_reg;
        if (cmd.load)
        begin
            rsp_next.cursor_column = cur_col_reg;
            rsp_next.cursor_row    = cur_row_reg;
            rsp_next.cell_char     = (req_reg.mode == MODE_READ) ? ram_rdata[7:0] : 8'd0;
            rsp_next.cell_color    = (req_reg.mode == MODE_READ) ? ram_rdata[15:8] : 8'd0;
        end
    end

    assign sts.clear_last  = (cnt_reg == AW'(CELLS - 1));
    assign sts.scroll_last = (cnt_reg == AW'(SCROLL_LEN));
    assign sts.need_scroll = need_scroll;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    assign rsp = rsp_reg;

    tccs_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

FILE: src/text_console_cursor_scroll_unit.sv
// Text console: an accepted request is carried out in the execute step. The
// result-load step waits while an unread result is held, then loads the result
// and takes the next request. A row advance past the bottom adds a row copy
// through the screen RAM's single write port.
// After reset a clearing pass writes blanks to all COLUMNS*ROWS cells, one per
// cycle; no request is taken until it ends. Cursor resets to 0,0; color to 7.
`default_nettype none

module text_console_cursor_scroll_unit
    import tccs_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire req_t        req,

    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output rsp_t             rsp,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    cmd_t       cmd;
    sts_t       sts;
    logic [7:0] text_color_reg;
    logic [7:0] text_color_next;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_TEXT_COLOR) && (paddr[1:0] == 2'b00);

    always_comb
    begin
        text_color_next = text_color_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            text_color_next = pwdata[7:0];
        end
    end

    assign prdata = reg_sel ? {24'd0, text_color_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= RESET_COLOR;
        end
        else
        begin
            text_color_reg <= text_color_next;
        end
    end

    tccs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    tccs_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .text_color (text_color_reg),
        .cmd        (cmd),
        .sts        (sts),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

FILE: bench/tb_text_console_cursor_scroll_unit.sv
// Self-checking testbench for text_console_cursor_scroll_unit: a queue-fed driver, a
// monitor that predicts each response from a local screen and cursor model, and APB setup.
// Depends on tccs_pkg and the unit's top level only.
`timescale 1ns / 1ps

module tb_text_console_cursor_scroll_unit;
    import tccs_pkg::*;

    localparam int COLS        = 80;
    localparam int LINES       = 25;
    localparam int CELLS       = COLS * LINES;
    localparam int CYCLE_LIMIT = 6_000_000;

    localparam logic [1:0] MODE_NONE       = 2'd3;
    localparam logic [2:0] ADDR_TEXT_COLOR = {REG_TEXT_COLOR, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED   = 3'd4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    req_t        req = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_t        rsp;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    text_console_cursor_scroll_unit #(
        .COLUMNS(COLS),
        .ROWS   (LINES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    req_t        queued_commands[$];
    rsp_t        pending_reports[$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          error_count = 0;
    int          cycle_count = 0;

    // Screen and cursor model
    logic [15:0] screen_model [0:CELLS-1];
    int          cur_col;
    int          cur_row;
    logic [7:0]  color_model;

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic void advance_model_row();
        if (cur_row + 1 >= LINES)
        begin
            cur_row = LINES - 1;
            // shift every row up; the bottom row keeps its contents
            for (int i = 0; i + COLS < CELLS; i++)
                screen_model[i] = screen_model[i + COLS];
        end
        else
        begin
            cur_row++;
        end
    endfunction

    function automatic void put_model_byte(input logic [7:0] ch);
        case (ch)
            CH_CR:
            begin
                cur_col = 0;
            end
            CH_LF:
            begin
                cur_col = 0;
                advance_model_row();
            end
            CH_TAB:
            begin
                cur_col += 5;
                if (cur_col >= COLS)
                begin
                    cur_col = 4;
                    advance_model_row();
                end
            end
            default:
            begin
                screen_model[cur_row * COLS + cur_col] = {color_model, ch};
                cur_col++;
                if (cur_col >= COLS)
                begin
                    cur_col = 0;
                    advance_model_row();
                end
            end
        endcase
    endfunction

    function automatic rsp_t console_apply(input req_t cmd);
        rsp_t result;
        int   col;
        int   row;
        int   idx;
        result = '0;
        col = (cmd.column > COLS - 1) ? COLS - 1 : cmd.column;
        row = (cmd.row > LINES - 1) ? LINES - 1 : cmd.row;
        case (cmd.mode)
            MODE_PUT:
            begin
                put_model_byte(cmd.char_code);
            end
            MODE_SET:
            begin
                cur_col = col;
                cur_row = row;
            end
            MODE_READ:
            begin
                idx = row * COLS + col;
                result.cell_char  = screen_model[idx][7:0];
                result.cell_color = screen_model[idx][15:8];
            end
            default:
            begin
            end
        endcase
        result.cursor_column = cur_col[6:0];
        result.cursor_row    = cur_row[4:0];
        return result;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (!req_valid || req_ready)
        begin
            if (queued_commands.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req_valid <= 1'b1;
                req       <= queued_commands.pop_front();
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check responses first, then predict the request taken at this edge
    always @(posedge clk)
    begin : monitor
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (pending_reports.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none, got %h", $time, rsp);
                    error_count++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    check_field("cursor_column", {1'b0, want.cursor_column},
                                {1'b0, rsp.cursor_column});
                    check_field("cursor_row", {3'b000, want.cursor_row},
                                {3'b000, rsp.cursor_row});
                    check_field("cell_char", want.cell_char, rsp.cell_char);
                    check_field("cell_color", want.cell_color, rsp.cell_color);
                end
            end
            if (req_valid && req_ready)
                pending_reports.push_back(console_apply(req));
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_text_console_cursor_scroll_unit: FAIL");
            $finish;
        end
    end

    task automatic apb_access(input logic write_en, input logic [2:0] addr,
                              input logic [31:0] data, output logic [31:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write_en;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
        logic [31:0] unused;
        apb_access(1'b1, addr, data, unused);
        if (addr == ADDR_TEXT_COLOR)
            color_model = data[7:0];
    endtask

    task automatic check_text_color();
        logic [31:0] rdata;
        apb_access(1'b0, ADDR_TEXT_COLOR, '0, rdata);
        if (rdata !== {24'd0, color_model})
        begin
            $display("%0t: text_color readback, expected %h, got %h", $time,
                     {24'd0, color_model}, rdata);
            error_count++;
        end
    endtask

    // Hold until every queued request is taken and every response is back
    task automatic wait_idle();
        do
            @(negedge clk);
        while (queued_commands.size() != 0 || req_valid || pending_reports.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic void queue_command(input logic [1:0] mode, input logic [7:0] ch,
                                          input int col, input int row);
        req_t cmd;
        cmd.mode      = mode;
        cmd.char_code = ch;
        cmd.column    = col[6:0];
        cmd.row       = row[4:0];
        queued_commands.push_back(cmd);
    endfunction

    function automatic logic [7:0] random_put_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return CH_CR;
        else if (pick < 20)
            return CH_LF;
        else if (pick < 35)
            return CH_TAB;
        return 8'($urandom_range(255));
    endfunction

    task automatic add_random_commands(input int count);
        int start;
        int kind;
        int col0;
        int row0;
        int len;
        int c;
        int r;
        @(negedge clk);
        start = queued_commands.size();
        while (queued_commands.size() - start < count)
        begin
            kind = $urandom_range(99);
            if (kind < 45)
            begin
                // place the cursor, print a burst, read the cells back
                col0 = ($urandom_range(99) < 40) ? $urandom_range(70, 79) : $urandom_range(79);
                row0 = $urandom_range(LINES - 1);
                len  = $urandom_range(1, 8);
                queue_command(MODE_SET, 8'($urandom), col0, row0);
                repeat (len) queue_command(MODE_PUT, random_put_byte(), $urandom, $urandom);
                for (int i = 0; i <= len; i++)
                begin
                    c = col0 + i;
                    r = row0;
                    if (c >= COLS)
                    begin
                        c -= COLS;
                        r++;
                    end
                    queue_command(MODE_READ, 8'($urandom), c, r);
                end
            end
            else if (kind < 60)
            begin
                // drive off the bottom row and look at what moved
                queue_command(MODE_SET, 8'($urandom), $urandom_range(127),
                              $urandom_range(23, 31));
                len = $urandom_range(1, 4);
                repeat (len)
                    queue_command(MODE_PUT, ($urandom_range(1) != 0) ? CH_LF : random_put_byte(),
                                  $urandom, $urandom);
                repeat (3)
                    queue_command(MODE_READ, 8'($urandom), $urandom_range(127),
                                  $urandom_range(22, 31));
            end
            else
            begin
                queue_command(2'($urandom_range(3)), 8'($urandom), $urandom_range(127),
                              $urandom_range(31));
            end
        end
    endtask

    initial
    begin : stimulus
        for (int i = 0; i < CELLS; i++)
            screen_model[i] = BLANK_CELL;
        cur_col     = 0;
        cur_row     = 0;
        color_model = RESET_COLOR;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 21;
        recv_idle_pct = 86;
        check_text_color();
        write_register(ADDR_UNMAPPED, 32'hFF);
        check_text_color();

        @(negedge clk);
        queue_command(MODE_READ, 8'h00, 0, 0);
        queue_command(MODE_READ, 8'hFF, 127, 31);      // saturates to the last cell
        queue_command(MODE_PUT, 8'h41, 0, 0);
        queue_command(MODE_PUT, 8'hFF, 127, 31);
        queue_command(MODE_PUT, 8'h00, 0, 0);
        queue_command(MODE_PUT, CH_TAB, 0, 0);
        queue_command(MODE_PUT, CH_CR, 0, 0);
        queue_command(MODE_PUT, CH_LF, 0, 0);
        queue_command(MODE_READ, 8'h00, 1, 0);
        queue_command(MODE_SET, 8'h00, 127, 31);
        queue_command(MODE_PUT, 8'h5A, 0, 0);          // wrap on the last row scrolls
        queue_command(MODE_READ, 8'h00, 79, 23);
        queue_command(MODE_READ, 8'h00, 79, 24);
        queue_command(MODE_SET, 8'h00, 77, 24);
        queue_command(MODE_PUT, CH_TAB, 0, 0);         // tab past the edge on the last row
        queue_command(MODE_SET, 8'h00, 75, 3);
        queue_command(MODE_PUT, CH_TAB, 0, 0);         // tab landing exactly on the width
        queue_command(MODE_SET, 8'h00, 74, 3);
        queue_command(MODE_PUT, CH_TAB, 0, 0);
        queue_command(MODE_PUT, 8'h78, 0, 0);
        queue_command(MODE_NONE, 8'hFF, 127, 31);
        queue_command(MODE_READ, 8'h00, 0, 0);
        queue_command(MODE_READ, 8'h00, 79, 3);
        wait_idle();

        write_register(ADDR_TEXT_COLOR, 32'hFF);
        check_text_color();
        add_random_commands(110);
        wait_idle();
        add_random_commands(110);
        wait_idle();

        send_idle_pct = 86;
        recv_idle_pct = 21;
        write_register(ADDR_TEXT_COLOR, 32'h00);
        check_text_color();
        add_random_commands(220);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_register(ADDR_TEXT_COLOR, $urandom);
        check_text_color();
        add_random_commands(210);
        wait_idle();

        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("tb_text_console_cursor_scroll_unit: PASS");
        else
            $display("tb_text_console_cursor_scroll_unit: FAIL");
        $finish;
    end

endmodule
